// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define THC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequence must hold in the cycle after its trigger.
`define THC_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/thc_pkg.sv =====
// Package of the compensation block: operation codes, register indexes, constants.
package thc_pkg;

	// Datapath operations issued by the controller, one per cycle unless the final step is held
	typedef enum logic [4:0] {
		OP_NONE   = 5'd0,
		OP_LOAD   = 5'd1,
		OP_T_M1   = 5'd2,
		OP_T_M2   = 5'd3,
		OP_T_M3   = 5'd4,
		OP_T_FINE = 5'd5,
		OP_T_M5   = 5'd6,
		OP_H_M1   = 5'd7,
		OP_H_A    = 5'd8,
		OP_H_B    = 5'd9,
		OP_H_C    = 5'd10,
		OP_H_M5   = 5'd11,
		OP_H_D    = 5'd12,
		OP_H_M7   = 5'd13,
		OP_H_E    = 5'd14,
		OP_H_M9   = 5'd15,
		OP_H_Q    = 5'd16,
		OP_H_M12  = 5'd17,
		OP_FINISH = 5'd18
	} op_t;

	// Status seen by the controller when a transaction arrives
	typedef struct packed {
		logic is_hum;
		logic short_path;
	} dp_status_t;

	// Configuration register indexes
	localparam logic [2:0] REG_TEMP_COEF_ONE      = 3'd0;
	localparam logic [2:0] REG_TEMP_COEF_TWO      = 3'd1;
	localparam logic [2:0] REG_TEMP_COEF_THREE    = 3'd2;
	localparam logic [2:0] REG_HUM_COEF_ONE       = 3'd3;
	localparam logic [2:0] REG_HUM_COEF_TWO       = 3'd4;
	localparam logic [2:0] REG_HUM_COEF_THREE     = 3'd5;
	localparam logic [2:0] REG_HUM_COEF_FOUR_FIVE = 3'd6;
	localparam logic [2:0] REG_HUM_COEF_SIX       = 3'd7;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SKIP   = 2'd1;
	localparam logic [1:0] ST_NOTEMP = 2'd2;

	// Sample kinds
	localparam logic KIND_TEMP = 1'b0;
	localparam logic KIND_HUM  = 1'b1;

	// Arithmetic constants
	localparam logic [19:0] SKIP_CODE   = 20'h80000;
	localparam logic [31:0] FINE_BIAS   = 32'd76800;
	localparam logic [31:0] HUM_ROUND   = 32'd16384;
	localparam logic [31:0] C_OFFSET    = 32'd32768;
	localparam logic [31:0] D_OFFSET    = 32'd2097152;
	localparam logic [31:0] E_ROUND     = 32'd8192;
	localparam logic [31:0] HUM_MAX     = 32'd419430400;
	localparam logic [31:0] TEMP_ROUND  = 32'd128;
	localparam logic [31:0] TEMP_SCALE  = 32'd5;

	// Operation that follows the given one in the temperature or humidity sequence
	function automatic op_t next_op(op_t cur);
		op_t nxt;
		unique case (cur)
			OP_T_M1:   nxt = OP_T_M2;
			OP_T_M2:   nxt = OP_T_M3;
			OP_T_M3:   nxt = OP_T_FINE;
			OP_T_FINE: nxt = OP_T_M5;
			OP_T_M5:   nxt = OP_FINISH;
			OP_H_M1:   nxt = OP_H_A;
			OP_H_A:    nxt = OP_H_B;
			OP_H_B:    nxt = OP_H_C;
			OP_H_C:    nxt = OP_H_M5;
			OP_H_M5:   nxt = OP_H_D;
			OP_H_D:    nxt = OP_H_M7;
			OP_H_M7:   nxt = OP_H_E;
			OP_H_E:    nxt = OP_H_M9;
			OP_H_M9:   nxt = OP_H_Q;
			OP_H_Q:    nxt = OP_H_M12;
			OP_H_M12:  nxt = OP_FINISH;
			default:   nxt = OP_NONE;
		endcase
		return nxt;
	endfunction

endpackage

// ===== src/thc_ctrl.sv =====
// Controller of the compensation block: sequences datapath operations and the handshakes.
module thc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  thc_pkg::dp_status_t status_in,
	output thc_pkg::op_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t       state_q;
	thc_pkg::op_t op_q;
	thc_pkg::op_t first_op;
	logic         out_valid_q;
	logic         out_free;

	// Output register may be reloaded when empty or being taken this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// First operation after the load: special cases go straight to the result
	always_comb begin
		if (status_in.short_path) begin
			first_op = thc_pkg::OP_FINISH;
		end else if (status_in.is_hum) begin
			first_op = thc_pkg::OP_H_M1;
		end else begin
			first_op = thc_pkg::OP_T_M1;
		end
	end

	// Command issue
	always_comb begin
		cmd = thc_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = thc_pkg::OP_LOAD;
				end
			end
			S_RUN: begin
				if (op_q != thc_pkg::OP_FINISH || out_free) begin
					cmd = op_q;
				end
			end
			default: cmd = thc_pkg::OP_NONE;
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= thc_pkg::OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						op_q    <= first_op;
					end
				end
				S_RUN: begin
					if (cmd != thc_pkg::OP_NONE) begin
						if (op_q == thc_pkg::OP_FINISH) begin
							state_q <= S_IDLE;
							op_q    <= thc_pkg::OP_NONE;
						end else begin
							op_q <= thc_pkg::next_op(op_q);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= thc_pkg::OP_NONE;
				end
			endcase
		end
	end

	// Output valid: set when a result is written, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == thc_pkg::OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/thc_dp.sv =====
// Datapath of the compensation block: coefficients, fine temperature, shared multiplier.
module thc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                func,
	input  logic [19:0]         raw_sample,
	input  thc_pkg::op_t        cmd,
	output thc_pkg::dp_status_t status_out,
	output logic                sample_kind,
	output logic signed [31:0]  temperature_centi,
	output logic [16:0]         humidity_q10,
	output logic [1:0]          status
);

	// Coefficient registers
	logic [15:0] t1_q;
	logic [15:0] t2_q;
	logic [15:0] t3_q;
	logic [7:0]  h1_q;
	logic [15:0] h2_q;
	logic [7:0]  h3_q;
	logic [23:0] h45_q;
	logic [7:0]  h6_q;
	logic [31:0] fine_q;

	// Working registers
	logic        kind_q;
	logic [1:0]  stat_q;
	logic [17:0] raw_q;	// only the bits that survive the shift by 14
	logic [31:0] p_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [31:0] z_q;
	logic [31:0] v_q;

	// Result registers
	logic        res_kind_q;
	logic [31:0] res_temp_q;
	logic [16:0] res_hum_q;
	logic [1:0]  res_stat_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic        mul_en;
	logic        is_skip;
	logic        no_fine;
	logic [31:0] t2_s;
	logic [31:0] t3_s;
	logic [31:0] h2_s;
	logic [31:0] h5_s;
	logic [31:0] h6_s;
	logic [31:0] d1;
	logic [31:0] d2;
	logic [31:0] a_pre;
	logic [31:0] p_sh4;
	logic [31:0] p_sh7;
	logic [31:0] p_sh10;
	logic [31:0] p_sh11;
	logic [31:0] p_sh12;
	logic [31:0] p_sh14;
	logic [31:0] p_sh15;
	logic [31:0] temp_val;
	logic [31:0] e_val;
	logic [31:0] hum_diff;
	logic [31:0] hum_clamp;

	// Special cases seen on the incoming transaction
	assign is_skip = (func == thc_pkg::KIND_TEMP) && (raw_sample == thc_pkg::SKIP_CODE);
	assign no_fine = (func == thc_pkg::KIND_HUM) && (fine_q == 32'd0);
	assign status_out.is_hum     = (func == thc_pkg::KIND_HUM);
	assign status_out.short_path = is_skip || no_fine;

	// Sign-extended coefficients
	assign t2_s = {{16{t2_q[15]}}, t2_q};
	assign t3_s = {{16{t3_q[15]}}, t3_q};
	assign h2_s = {{16{h2_q[15]}}, h2_q};
	assign h5_s = {{20{h45_q[23]}}, h45_q[23:12]};
	assign h6_s = {{24{h6_q[7]}}, h6_q};

	// Temperature differences taken at load
	assign d1 = {15'd0, raw_sample[19:3]} - {15'd0, t1_q, 1'b0};
	assign d2 = {16'd0, raw_sample[19:4]} - {16'd0, t1_q};

	// Arithmetic shifts of the product register
	assign p_sh4  = 32'($signed(p_q) >>> 4);
	assign p_sh7  = 32'($signed(p_q) >>> 7);
	assign p_sh10 = 32'($signed(p_q) >>> 10);
	assign p_sh11 = 32'($signed(p_q) >>> 11);
	assign p_sh12 = 32'($signed(p_q) >>> 12);
	assign p_sh14 = 32'($signed(p_q) >>> 14);
	assign p_sh15 = 32'($signed(p_q) >>> 15);

	// Humidity offset term, gain term and temperature result
	assign a_pre    = {raw_q, 14'd0} - {h45_q[11:0], 20'd0} - p_q + thc_pkg::HUM_ROUND;
	assign e_val    = 32'($signed(p_q + thc_pkg::E_ROUND) >>> 14);
	assign temp_val = 32'($signed(p_q + thc_pkg::TEMP_ROUND) >>> 8);

	// Final humidity: subtract square term and clamp
	assign hum_diff = x_q - p_sh4;
	always_comb begin
		if (hum_diff[31]) begin
			hum_clamp = 32'd0;
		end else if (hum_diff > thc_pkg::HUM_MAX) begin
			hum_clamp = thc_pkg::HUM_MAX;
		end else begin
			hum_clamp = hum_diff;
		end
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_a  = 32'd0;
		mul_b  = 32'd0;
		mul_en = 1'b1;
		unique case (cmd)
			thc_pkg::OP_T_M1: begin
				mul_a = x_q;
				mul_b = t2_s;
			end
			thc_pkg::OP_T_M2: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			thc_pkg::OP_T_M3: begin
				mul_a = p_sh12;
				mul_b = t3_s;
			end
			thc_pkg::OP_T_M5: begin
				mul_a = fine_q;
				mul_b = thc_pkg::TEMP_SCALE;
			end
			thc_pkg::OP_H_M1: begin
				mul_a = h5_s;
				mul_b = v_q;
			end
			thc_pkg::OP_H_A: begin
				mul_a = v_q;
				mul_b = h6_s;
			end
			thc_pkg::OP_H_B: begin
				mul_a = v_q;
				mul_b = {24'd0, h3_q};
			end
			thc_pkg::OP_H_M5: begin
				mul_a = y_q;
				mul_b = z_q;
			end
			thc_pkg::OP_H_M7: begin
				mul_a = y_q;
				mul_b = h2_s;
			end
			thc_pkg::OP_H_M9: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			thc_pkg::OP_H_Q: begin
				mul_a = p_sh15;
				mul_b = p_sh15;
			end
			thc_pkg::OP_H_M12: begin
				mul_a = p_sh7;
				mul_b = {24'd0, h1_q};
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Low 32 bits of the product: every intermediate wraps at 32 bits
	assign prod = mul_a * mul_b;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			h45_q <= '0;
			h6_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thc_pkg::REG_TEMP_COEF_ONE:      t1_q  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_COEF_TWO:      t2_q  <= cfg_data[15:0];
				thc_pkg::REG_TEMP_COEF_THREE:    t3_q  <= cfg_data[15:0];
				thc_pkg::REG_HUM_COEF_ONE:       h1_q  <= cfg_data[7:0];
				thc_pkg::REG_HUM_COEF_TWO:       h2_q  <= cfg_data[15:0];
				thc_pkg::REG_HUM_COEF_THREE:     h3_q  <= cfg_data[7:0];
				thc_pkg::REG_HUM_COEF_FOUR_FIVE: h45_q <= cfg_data;
				thc_pkg::REG_HUM_COEF_SIX:       h6_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stored fine temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (cmd == thc_pkg::OP_T_FINE) begin
			fine_q <= x_q + p_sh14;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= prod;
		end
	end

	// Working registers written by the sequence
	always_ff @(posedge clk) begin
		unique case (cmd)
			thc_pkg::OP_LOAD: begin
				kind_q <= func;
				raw_q  <= raw_sample[17:0];
				x_q    <= d1;
				y_q    <= d2;
				v_q    <= fine_q - thc_pkg::FINE_BIAS;
				if (is_skip) begin
					stat_q <= thc_pkg::ST_SKIP;
				end else if (no_fine) begin
					stat_q <= thc_pkg::ST_NOTEMP;
				end else begin
					stat_q <= thc_pkg::ST_OK;
				end
			end
			thc_pkg::OP_T_M2: x_q <= p_sh11;
			thc_pkg::OP_H_A:  x_q <= 32'($signed(a_pre) >>> 15);
			thc_pkg::OP_H_B:  y_q <= p_sh10;
			thc_pkg::OP_H_C:  z_q <= p_sh11 + thc_pkg::C_OFFSET;
			thc_pkg::OP_H_D:  y_q <= p_sh10 + thc_pkg::D_OFFSET;
			thc_pkg::OP_H_E:  y_q <= e_val;
			thc_pkg::OP_H_Q:  x_q <= p_q;
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd == thc_pkg::OP_FINISH) begin
			res_kind_q <= kind_q;
			res_stat_q <= stat_q;
			res_temp_q <= 32'd0;
			res_hum_q  <= 17'd0;
			if (stat_q == thc_pkg::ST_OK) begin
				if (kind_q == thc_pkg::KIND_TEMP) begin
					res_temp_q <= temp_val;
				end else begin
					res_hum_q <= hum_clamp[28:12];
				end
			end
		end
	end

	assign sample_kind       = res_kind_q;
	assign temperature_centi = $signed(res_temp_q);
	assign humidity_q10      = res_hum_q;
	assign status            = res_stat_q;

endmodule

// ===== src/temp_humidity_compensation_core.sv =====
// Top level of the temperature and humidity compensation block.
//
// Input channel in_valid/in_ready carries func (0 temperature, 1 humidity) and
// raw_sample. Output channel out_valid/out_ready returns one result per
// transaction: sample_kind, temperature_centi, humidity_q10 and status.
// Coefficients are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block does not enforce. A skipped
// temperature or a humidity sample with no fine temperature stored goes from
// the load straight to the final step; others run their sequence first. A new
// transaction is accepted the cycle after a result is written, not before.
// Operations issue one a cycle unless held; those that multiply use the single
// shared 32x32 multiplier. The result sits in an output register: the next
// transaction is accepted and worked on while it waits. If the receiver still
// stalls when the next result is ready, the sequencer holds on its final step
// until the register frees. Reset clears the coefficients, the stored fine
// temperature and all control state; the block is ready right after reset.
`include "assert_macros.svh"

module temp_humidity_compensation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [19:0]        raw_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               sample_kind,
	output logic signed [31:0] temperature_centi,
	output logic [16:0]        humidity_q10,
	output logic [1:0]         status
);

	thc_pkg::op_t       cmd;
	thc_pkg::dp_status_t dp_status;

	// Sequencer
	thc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status_in (dp_status),
		.cmd       (cmd)
	);

	// Arithmetic and storage
	thc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.func              (func),
		.raw_sample        (raw_sample),
		.cmd               (cmd),
		.status_out        (dp_status),
		.sample_kind       (sample_kind),
		.temperature_centi (temperature_centi),
		.humidity_q10      (humidity_q10),
		.status            (status)
	);

	// Checks
	`THC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"accepted a transaction without going busy")
	`THC_ASSERT(a_no_overwrite, (cmd == thc_pkg::OP_FINISH) |-> (!out_valid || out_ready),
		"result written over an untaken result")
	`THC_ASSERT(a_temp_no_hum, (out_valid && sample_kind == thc_pkg::KIND_TEMP) |->
		(humidity_q10 == 17'd0), "temperature result with nonzero humidity")
	`THC_ASSERT(a_special_zero, (out_valid && status != thc_pkg::ST_OK) |->
		(temperature_centi == 32'sd0 && humidity_q10 == 17'd0),
		"special-case result with nonzero value")

endmodule

// ===== tb/sv/temp_humidity_compensation_core_test.sv =====
// Self-checking testbench for the temperature and humidity compensation core.
module temp_humidity_compensation_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 6;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1230;
	localparam int CALM_TAIL    = 150;
	localparam int MAX_REPORTS  = 10;

	// Typical calibration of a 32-bit integer compensation part
	localparam logic [23:0] TYP_T1  = 24'd27504;
	localparam logic [23:0] TYP_T2  = 24'd26435;
	localparam logic [23:0] TYP_T3  = 24'hFFFC18;	// -1000
	localparam logic [23:0] TYP_H1  = 24'd75;
	localparam logic [23:0] TYP_H2  = 24'd362;
	localparam logic [23:0] TYP_H3  = 24'd0;
	localparam logic [23:0] TYP_H45 = {12'd50, 12'd313};
	localparam logic [23:0] TYP_H6  = 24'd30;

	// One result transaction
	typedef struct packed {
		logic        kind;
		logic [31:0] temp;
		logic [16:0] hum;
		logic [1:0]  status;
	} reading_t;

	// One row of the directed part
	typedef struct packed {
		logic        typical;	// 0: reset coefficients, 1: typical calibration
		logic        func;
		logic [19:0] raw;
		logic        typed;	// expected result given in the row
		reading_t    result;
	} stim_row_t;

	localparam int N_ROWS = 22;

	stim_row_t directed_rows [N_ROWS] = '{
		// reset coefficients: humidity right after reset has no temperature
		'{1'b0, thc_pkg::KIND_HUM, 20'h00000, 1'b1,
			'{thc_pkg::KIND_HUM, 32'd0, 17'd0, thc_pkg::ST_NOTEMP}},
		'{1'b0, thc_pkg::KIND_TEMP, 20'h80000, 1'b1,
			'{thc_pkg::KIND_TEMP, 32'd0, 17'd0, thc_pkg::ST_SKIP}},
		'{1'b0, thc_pkg::KIND_TEMP, 20'h00000, 1'b1,
			'{thc_pkg::KIND_TEMP, 32'd0, 17'd0, thc_pkg::ST_OK}},
		'{1'b0, thc_pkg::KIND_TEMP, 20'hFFFFF, 1'b1,
			'{thc_pkg::KIND_TEMP, 32'd0, 17'd0, thc_pkg::ST_OK}},
		// zero coefficients leave the fine value at zero
		'{1'b0, thc_pkg::KIND_HUM, 20'hFFFFF, 1'b1,
			'{thc_pkg::KIND_HUM, 32'd0, 17'd0, thc_pkg::ST_NOTEMP}},
		// typical calibration
		'{1'b1, thc_pkg::KIND_TEMP, 20'd519888, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'd30000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'h00000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'h0FFFF, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'hFFFFF, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_TEMP, 20'h80000, 1'b1,
			'{thc_pkg::KIND_TEMP, 32'd0, 17'd0, thc_pkg::ST_SKIP}},
		// stored fine value survives the skipped sample
		'{1'b1, thc_pkg::KIND_HUM,  20'd45000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_TEMP, 20'h00000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'd40000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_TEMP, 20'hFFFFF, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'h80000, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_TEMP, 20'h7FFFF, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'h7FFFF, 1'b0, '0},
		// raw = 16 * offset coefficient gives a real fine value of exactly zero
		'{1'b1, thc_pkg::KIND_TEMP, 20'd440064, 1'b1,
			'{thc_pkg::KIND_TEMP, 32'd0, 17'd0, thc_pkg::ST_OK}},
		'{1'b1, thc_pkg::KIND_HUM, 20'd32000, 1'b1,
			'{thc_pkg::KIND_HUM, 32'd0, 17'd0, thc_pkg::ST_NOTEMP}},
		'{1'b1, thc_pkg::KIND_TEMP, 20'h80001, 1'b0, '0},
		'{1'b1, thc_pkg::KIND_HUM,  20'h00001, 1'b0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = 1'b0;
	logic [19:0]        raw_sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               sample_kind;
	logic signed [31:0] temperature_centi;
	logic [16:0]        humidity_q10;
	logic [1:0]         status;

	temp_humidity_compensation_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.func              (func),
		.raw_sample        (raw_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.sample_kind       (sample_kind),
		.temperature_centi (temperature_centi),
		.humidity_q10      (humidity_q10),
		.status            (status)
	);

	// Shadow coefficients and stored fine temperature
	logic [15:0] k_t1, k_t2, k_t3, k_h2;
	logic [7:0]  k_h1, k_h3, k_h6;
	logic [23:0] k_h45;
	logic [31:0] fine_temp;

	reading_t    pending_readings [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          ready_hold = 0;
	bit          idle_on = 1'b1;

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] sra(logic [31:0] x, int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic void store_coef(logic [2:0] idx, logic [23:0] data);
		case (idx)
			thc_pkg::REG_TEMP_COEF_ONE:      k_t1 = data[15:0];
			thc_pkg::REG_TEMP_COEF_TWO:      k_t2 = data[15:0];
			thc_pkg::REG_TEMP_COEF_THREE:    k_t3 = data[15:0];
			thc_pkg::REG_HUM_COEF_ONE:       k_h1 = data[7:0];
			thc_pkg::REG_HUM_COEF_TWO:       k_h2 = data[15:0];
			thc_pkg::REG_HUM_COEF_THREE:     k_h3 = data[7:0];
			thc_pkg::REG_HUM_COEF_FOUR_FIVE: k_h45 = data;
			thc_pkg::REG_HUM_COEF_SIX:       k_h6 = data[7:0];
			default: ;
		endcase
	endfunction

	// Integer compensation of one sample; updates the stored fine temperature
	function automatic reading_t compensate_sample(logic f, logic [19:0] raw);
		reading_t r;
		logic [31:0] w, t1, t2, t3, d1, d2, v1, v2;
		logic [31:0] h1, h2, h3, h4, h5, h6, vt, a, b, c, d, e, v, q, fq;
		r = '0;
		r.kind = f;
		r.status = thc_pkg::ST_OK;
		w = {12'd0, raw};
		if (f == thc_pkg::KIND_TEMP) begin
			if (raw == thc_pkg::SKIP_CODE) begin
				r.status = thc_pkg::ST_SKIP;
			end else begin
				t1 = {16'd0, k_t1};
				t2 = {{16{k_t2[15]}}, k_t2};
				t3 = {{16{k_t3[15]}}, k_t3};
				d1 = (w >> 3) - (t1 << 1);
				v1 = d1 * t2;
				v1 = sra(v1, 11);
				d2 = (w >> 4) - t1;
				v2 = d2 * d2;
				v2 = sra(v2, 12);
				v2 = v2 * t3;
				v2 = sra(v2, 14);
				fine_temp = v1 + v2;
				v = fine_temp * thc_pkg::TEMP_SCALE + thc_pkg::TEMP_ROUND;
				r.temp = sra(v, 8);
			end
		end else if (fine_temp == 32'd0) begin
			r.status = thc_pkg::ST_NOTEMP;
		end else begin
			h1 = {24'd0, k_h1};
			h2 = {{16{k_h2[15]}}, k_h2};
			h3 = {24'd0, k_h3};
			h4 = {{20{k_h45[11]}}, k_h45[11:0]};
			h5 = {{20{k_h45[23]}}, k_h45[23:12]};
			h6 = {{24{k_h6[7]}}, k_h6};
			vt = fine_temp - thc_pkg::FINE_BIAS;
			a = (w << 14) - (h4 << 20) - (h5 * vt) + thc_pkg::HUM_ROUND;
			a = sra(a, 15);
			b = vt * h6;
			b = sra(b, 10);
			c = vt * h3;
			c = sra(c, 11) + thc_pkg::C_OFFSET;
			d = b * c;
			d = sra(d, 10) + thc_pkg::D_OFFSET;
			e = d * h2 + thc_pkg::E_ROUND;
			e = sra(e, 14);
			v = a * e;
			q = sra(v, 15);
			fq = q * q;
			fq = sra(fq, 7) * h1;
			fq = sra(fq, 4);
			v = v - fq;
			if (v[31])
				v = 32'd0;
			if (v > thc_pkg::HUM_MAX)
				v = thc_pkg::HUM_MAX;
			r.hum = v[28:12];
		end
		return r;
	endfunction

	// Write all eight coefficient registers back to back
	task automatic program_coefs(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
			logic [23:0] c3, logic [23:0] c4, logic [23:0] c5, logic [23:0] c6,
			logic [23:0] c7);
		logic [23:0] vals [8];
		vals = '{c0, c1, c2, c3, c4, c5, c6, c7};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data <= vals[i];
			store_coef(i[2:0], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// Offer one sample transaction and queue its expected result on acceptance
	task automatic send_sample(logic f, logic [19:0] raw, logic typed, reading_t given);
		reading_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		raw_sample <= raw;
		do
			@(posedge clk);
		while (!in_ready);
		r = compensate_sample(f, raw);
		pending_readings.push_back(typed ? given : r);
	endtask

	// Result side: compare each transaction, stall out_ready in bursts
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		if (out_valid && out_ready) begin
			got = '{sample_kind, temperature_centi, humidity_q10, status};
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: kind %0d temp %0d hum %0d status %0d",
						got.kind, $signed(got.temp), got.hum, got.status);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch: expected kind %0d temp %0d hum %0d status %0d",
							want.kind, $signed(want.temp), want.hum, want.status);
						$display("          got      kind %0d temp %0d hum %0d status %0d",
							got.kind, $signed(got.temp), got.hum, got.status);
					end
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Random content; mostly temperature/humidity pairs in a realistic range
	task automatic send_random(ref int sent);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				send_sample(thc_pkg::KIND_TEMP, 20'($urandom_range(400000, 600000)),
					1'b0, '0);
				send_sample(thc_pkg::KIND_HUM, 20'($urandom_range(15000, 55000)),
					1'b0, '0);
				sent += 2;
			end
			6: begin
				send_sample(thc_pkg::KIND_TEMP, thc_pkg::SKIP_CODE, 1'b0, '0);
				sent++;
			end
			7: begin
				send_sample(thc_pkg::KIND_TEMP, 20'($urandom), 1'b0, '0);
				sent++;
			end
			8: begin
				send_sample(thc_pkg::KIND_HUM, 20'($urandom), 1'b0, '0);
				sent++;
			end
			default: begin
				send_sample(thc_pkg::KIND_HUM, 20'($urandom_range(0, 65535)), 1'b0, '0);
				sent++;
			end
		endcase
	endtask

	// Main sequence
	initial begin
		int sent;
		int block_mark;
		int phase_end;
		k_t1 = '0; k_t2 = '0; k_t3 = '0; k_h1 = '0;
		k_h2 = '0; k_h3 = '0; k_h45 = '0; k_h6 = '0;
		fine_temp = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < N_ROWS; i++) begin
			if (directed_rows[i].typical && (i == 0 || !directed_rows[i - 1].typical)) begin
				drain_results();
				program_coefs(TYP_T1, TYP_T2, TYP_T3, TYP_H1, TYP_H2, TYP_H3, TYP_H45, TYP_H6);
			end
			send_sample(directed_rows[i].func, directed_rows[i].raw,
				directed_rows[i].typed, directed_rows[i].result);
		end

		// Random part over several calibrations, extremes included
		sent = 0;
		block_mark = 0;
		for (int phase = 0; phase < 7; phase++) begin
			drain_results();
			case (phase)
				0: program_coefs(TYP_T1, TYP_T2, TYP_T3, TYP_H1, TYP_H2, TYP_H3, TYP_H45, TYP_H6);
				1: program_coefs(24'h00FFFF, 24'h007FFF, 24'h007FFF, 24'h0000FF,
					24'h007FFF, 24'h0000FF, 24'hFFFFFF, 24'h00007F);
				2: program_coefs(24'h000000, 24'h008000, 24'h008000, 24'h000000,
					24'h008000, 24'h000000, 24'h800800, 24'h000080);
				6: program_coefs(TYP_T1, TYP_T2, TYP_T3, TYP_H1, TYP_H2, TYP_H3, TYP_H45, TYP_H6);
				default: program_coefs(24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			endcase
			phase_end = (phase == 6) ? RANDOM_ITEMS : ((phase + 1) * RANDOM_ITEMS) / 7;
			while (sent < phase_end) begin
				if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
					idle_on = 1'b0;
				end else if (sent >= block_mark) begin
					// stretches with and without idling
					idle_on = ($urandom_range(0, 3) != 0);
					block_mark = sent + 40;
				end
				send_random(sent);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
